// ===== hdl/jls_pkg.sv =====
// Shared types and constants for the Jacobi Laplace stencil block.
// No dependencies; imported by jacobi_laplace_stencil.
package jls_pkg;

  // Field widths of the item and register words.
  localparam int ACTION_W    = 2;
  localparam int COORD_W     = 7;
  localparam int WORD_W      = 32;
  localparam int GRID_SIZE_W = 7;
  localparam int SWEEP_W     = 10;
  localparam int CFG_DATA_W  = 10;

  typedef logic [ACTION_W-1:0]    action_t;
  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [GRID_SIZE_W-1:0] grid_size_t;
  typedef logic [SWEEP_W-1:0]     sweep_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic                   cfg_index_t;

  // Action codes of an input word.
  localparam action_t ACT_WRITE = 2'd0;
  localparam action_t ACT_RUN   = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam cfg_index_t CFG_GRID_SIZE   = 1'b0;
  localparam cfg_index_t CFG_SWEEP_COUNT = 1'b1;

  // Register reset values.
  localparam grid_size_t GRID_SIZE_RST   = 7'd50;
  localparam sweep_t     SWEEP_COUNT_RST = 10'd100;

endpackage

// ===== hdl/jacobi_laplace_stencil.sv =====
// A write, an unused action and an out-of-array read answer in the cycle after the word
// is taken; an in-array read passes the registered bank read port and ST_READ first.
// A run sweeps every cell sweep_count times with one shared accumulate unit and one read
// port per grid bank; no new word is taken meanwhile. After reset a clearing pass zeroes
// bank A's (MAX_GRID_N+1)^2 cells (4225 by default) one cell a cycle, taking no input word.
// Reset is synchronous, active low; configuration writes are taken at any time.
module jacobi_laplace_stencil #(
  parameter int MAX_GRID_N  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  jls_pkg::action_t   in_action,
  input  jls_pkg::coord_t    in_row,
  input  jls_pkg::coord_t    in_col,
  input  jls_pkg::word_t     in_cell_value,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output jls_pkg::word_t     out_read_value,
  output logic               out_run_done,
  // Configuration channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  jls_pkg::cfg_index_t cfg_index,
  input  jls_pkg::cfg_data_t cfg_data
);
  import jls_pkg::*;

  localparam int SIDE   = MAX_GRID_N + 1;
  localparam int CELLS  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(SIDE);
  localparam int ACC_W  = VALUE_WIDTH + 2;

  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic signed [VALUE_WIDTH-1:0] cell_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  localparam addr_t LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam addr_t SIDE_ADDR = ADDR_W'(SIDE);
  localparam idx_t  LAST_IDX  = IDX_W'(MAX_GRID_N);

  // Grid banks.
  cell_t bank_a [CELLS];
  cell_t bank_b [CELLS];

  // Control and datapath registers.
  state_t     state_r, state_nxt;
  addr_t      addr_r, addr_nxt;
  idx_t       row_r, row_nxt;
  idx_t       col_r, col_nxt;
  logic [2:0] phase_r, phase_nxt;
  acc_t       acc_r, acc_nxt;
  logic       bank_r, bank_nxt;
  sweep_t     sweep_cnt_r, sweep_cnt_nxt;
  idx_t       gs_r, gs_nxt;
  grid_size_t grid_size_r, grid_size_nxt;
  sweep_t     sweep_count_r, sweep_count_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_value_r, out_value_nxt;
  logic       out_done_r, out_done_nxt;

  // Memory port signals.
  addr_t rd_addr;
  cell_t rdata_a_r, rdata_b_r;
  cell_t src_data;
  logic  wr_en;
  logic  wr_bank;
  addr_t wr_addr;
  cell_t wr_data;

  // Decoded input word.
  logic  in_ready;
  logic  in_fire;
  logic  in_array;
  addr_t host_addr;
  logic  interior;
  acc_t  quad_sum;
  logic  last_cell;
  logic  last_sweep;
  idx_t  gs_clamped;

  assign in_array  = (32'(in_row) <= MAX_GRID_N) && (32'(in_col) <= MAX_GRID_N);
  assign host_addr = ADDR_W'(32'(in_row) * SIDE + 32'(in_col));
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || !out_stall);
  assign in_fire   = in_valid && in_ready;
  assign in_stall  = !in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_run_done   = out_done_r;

  assign gs_clamped = (32'(grid_size_r) > MAX_GRID_N) ? LAST_IDX : IDX_W'(grid_size_r);

  // Source cell data from the current bank.
  assign src_data = bank_r ? rdata_b_r : rdata_a_r;

  // Cell classification, the running sum of the four neighbors, and the last-cell and last-sweep flags.
  assign interior   = (row_r != '0) && (col_r != '0) && (row_r < gs_r) && (col_r < gs_r);
  assign quad_sum   = acc_r + ACC_W'(src_data);
  assign last_cell  = (addr_r == LAST_ADDR);
  assign last_sweep = ({1'b0, sweep_cnt_r} + 11'd1) == {1'b0, sweep_count_r};

  // Sequencer next-state logic.
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    bank_nxt        = bank_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    gs_nxt          = gs_r;
    grid_size_nxt   = grid_size_r;
    sweep_count_nxt = sweep_count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_value_nxt   = out_value_r;
    out_done_nxt    = out_done_r;
    rd_addr         = addr_r;
    wr_en           = 1'b0;
    wr_bank         = bank_r;
    wr_addr         = addr_r;
    wr_data         = src_data;

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_SIZE:   grid_size_nxt   = cfg_data[GRID_SIZE_W-1:0];
        CFG_SWEEP_COUNT: sweep_count_nxt = cfg_data[SWEEP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      // Zero bank A one cell a cycle.
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_bank = 1'b0;
        wr_data = '0;
        if (last_cell) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // Take a word and dispatch on its action.
      ST_IDLE: begin
        rd_addr = host_addr;
        if (in_fire) begin
          out_value_nxt = '0;
          out_done_nxt  = 1'b0;
          case (in_action)
            ACT_WRITE: begin
              wr_en         = in_array;
              wr_addr       = host_addr;
              wr_data       = VALUE_WIDTH'(in_cell_value);
              out_valid_nxt = 1'b1;
            end
            ACT_RUN: begin
              if (sweep_count_r == '0) begin
                out_done_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                addr_nxt      = '0;
                row_nxt       = '0;
                col_nxt       = '0;
                phase_nxt     = '0;
                sweep_cnt_nxt = '0;
                gs_nxt        = gs_clamped;
                state_nxt     = ST_SWEEP;
              end
            end
            ACT_READ: begin
              if (in_array) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Read data is back; load it into the output register.
      ST_READ: begin
        out_value_nxt = WORD_W'(src_data);
        out_done_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // One cell per pass: read neighbors one at a time and accumulate; a cell outside the interior is copied.
      ST_SWEEP: begin
        wr_bank = !bank_r;
        case (phase_r)
          3'd0: begin
            rd_addr   = interior ? (addr_r - 1'b1) : addr_r;
            acc_nxt   = '0;
            phase_nxt = 3'd1;
          end
          3'd1: begin
            rd_addr   = addr_r + 1'b1;
            acc_nxt   = ACC_W'(src_data);
            phase_nxt = interior ? 3'd2 : 3'd0;
            wr_en     = !interior;
            wr_data   = src_data;
          end
          3'd2: begin
            rd_addr   = addr_r - SIDE_ADDR;
            acc_nxt   = quad_sum;
            phase_nxt = 3'd3;
          end
          3'd3: begin
            rd_addr   = addr_r + SIDE_ADDR;
            acc_nxt   = quad_sum;
            phase_nxt = 3'd4;
          end
          default: begin
            wr_en     = 1'b1;
            wr_data   = quad_sum[ACC_W-1:2];
            phase_nxt = 3'd0;
          end
        endcase

        // Step to the next cell once this one is written.
        if (wr_en) begin
          if (last_cell) begin
            addr_nxt      = '0;
            row_nxt       = '0;
            col_nxt       = '0;
            bank_nxt      = !bank_r;
            sweep_cnt_nxt = sweep_cnt_r + 1'b1;
            if (last_sweep) begin
              out_value_nxt = '0;
              out_done_nxt  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else begin
            addr_nxt = addr_r + 1'b1;
            if (col_r == LAST_IDX) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      addr_r        <= '0;
      row_r         <= '0;
      col_r         <= '0;
      phase_r       <= '0;
      bank_r        <= 1'b0;
      sweep_cnt_r   <= '0;
      gs_r          <= '0;
      grid_size_r   <= GRID_SIZE_RST;
      sweep_count_r <= SWEEP_COUNT_RST;
      out_valid_r   <= 1'b0;
      out_done_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      addr_r        <= addr_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      phase_r       <= phase_nxt;
      bank_r        <= bank_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      gs_r          <= gs_nxt;
      grid_size_r   <= grid_size_nxt;
      sweep_count_r <= sweep_count_nxt;
      out_valid_r   <= out_valid_nxt;
      out_done_r    <= out_done_nxt;
    end
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  // Bank A: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank_a[wr_addr] <= wr_data;
    end
    rdata_a_r <= bank_a[rd_addr];
  end

  // Bank B: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      bank_b[wr_addr] <= wr_data;
    end
    rdata_b_r <= bank_b[rd_addr];
  end

endmodule
